// ----- src/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// hts_pkg: shared types and codes for the heap top-k selector
// Datapath command codes, command/status structs and fixed field widths.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int POSITION_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SORTED_OUTPUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGEST_MODE  = 2'd2;

    // datapath operations
    localparam logic [3:0] DP_NOP     = 4'd0;
    localparam logic [3:0] DP_LOAD    = 4'd1;
    localparam logic [3:0] DP_RD_ROOT = 4'd2;
    localparam logic [3:0] DP_REPLACE = 4'd3;
    localparam logic [3:0] DP_SIFT_RD = 4'd4;
    localparam logic [3:0] DP_SIFT_ST = 4'd5;
    localparam logic [3:0] DP_SWAP_RD = 4'd6;
    localparam logic [3:0] DP_SWAP    = 4'd7;
    localparam logic [3:0] DP_RB_RD   = 4'd8;
    localparam logic [3:0] DP_RB_WR   = 4'd9;
    localparam logic [3:0] DP_BP_RD   = 4'd10;
    localparam logic [3:0] DP_BP_LD   = 4'd11;
    localparam logic [3:0] DP_EM_RD   = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic       capture;   // input transaction this cycle, latch sample
        logic       largest;   // row ordering: keep largest values
    } hts_cmd_t;

    typedef struct packed {
        logic beaten;          // sample strictly better than root
        logic stop;            // sift-down finished this step
    } hts_stat_t;

endpackage

// ----- src/hts_intf.sv -----
// ----------------------------------------------------------------------------
// hts_intf: stream interfaces of the heap top-k selector
// Sample input channel and position output channel, valid/ready.
// ----------------------------------------------------------------------------
interface hts_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [hts_pkg::SAMPLE_W-1:0] sample_value;
    logic                                row_end;

    modport source (output valid, output sample_value, output row_end, input ready);
    modport sink   (input valid, input sample_value, input row_end, output ready);
endinterface

interface hts_out_if;
    logic                            valid;
    logic                            ready;
    logic [hts_pkg::POSITION_W-1:0]  position;
    logic                            final_result;

    modport source (output valid, output position, output final_result, input ready);
    modport sink   (input valid, input position, input final_result, output ready);
endinterface

// ----- src/hts_datapath.sv -----
// ----------------------------------------------------------------------------
// hts_datapath: heap storage and sift-down compare unit
// Heap and by-position memories with registered reads, moving-entry register.
// ----------------------------------------------------------------------------
module hts_datapath #(
    parameter int MAX_K      = 16,
    parameter int MAX_N      = 65536,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  hts_pkg::hts_cmd_t                   cmd,
    input  logic [(MAX_K > 1 ? $clog2(MAX_K) : 1)-1:0] addr,
    input  logic [$clog2(MAX_K + 1)-1:0]        size_arg,
    input  logic [$clog2(MAX_N)-1:0]            pos_arg,
    input  logic signed [hts_pkg::SAMPLE_W-1:0] sample_value,
    output hts_pkg::hts_stat_t                  stat,
    output logic [$clog2(MAX_N)-1:0]            rd_pos
);

    localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW = $clog2(MAX_K + 1);
    localparam int SW  = KCW + 1;
    localparam int PW  = $clog2(MAX_N);
    localparam int EXT = (VALUE_BITS > hts_pkg::SAMPLE_W) ? VALUE_BITS : hts_pkg::SAMPLE_W;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    function automatic logic better(input logic largest, input val_t a, input val_t b);
        better = largest ? (a > b) : (a < b);
    endfunction

    // a worse than b: worse value, or equal value at a higher position
    function automatic logic worse(input logic largest, input val_t av, input logic [PW-1:0] ap,
                                   input val_t bv, input logic [PW-1:0] bp);
        if (av == bv)
            worse = ap > bp;
        else
            worse = better(largest, bv, av);
    endfunction

    val_t            heap_val_mem [MAX_K];
    logic [PW-1:0]   heap_pos_mem [MAX_K];
    val_t            bp_mem       [MAX_K];

    val_t            rda_val_reg, rdb_val_reg, bp_rd_reg, key_reg, cur_val_reg;
    val_t            cur_val_next;
    logic [PW-1:0]   rda_pos_reg, rdb_pos_reg, cur_pos_reg, cur_pos_next;
    logic [KW-1:0]   idx_reg, idx_next;
    logic [KCW-1:0]  size_reg, size_next;

    logic signed [EXT-1:0] sample_ext;
    val_t            key_in;
    logic [SW-1:0]   l_full, r_full;
    logic [KW-1:0]   l_sel, r_sel, ra, rb;
    logic            has_l, has_r, worse_l, worse_r, go_l, go_r, beaten;
    logic            we, bp_we;
    logic [KW-1:0]   wa;
    val_t            wv;
    logic [PW-1:0]   wp;

    assign sample_ext = EXT'(sample_value);
    assign key_in     = sample_ext[VALUE_BITS-1:0];

    assign l_full = (SW'(idx_reg) << 1) + SW'(1);
    assign r_full = l_full + SW'(1);
    assign l_sel  = (l_full < SW'(MAX_K)) ? KW'(l_full) : '0;
    assign r_sel  = (r_full < SW'(MAX_K)) ? KW'(r_full) : '0;
    assign has_l  = l_full < SW'(size_reg);
    assign has_r  = r_full < SW'(size_reg);

    assign worse_l = worse(cmd.largest, rda_val_reg, rda_pos_reg, cur_val_reg, cur_pos_reg);
    assign worse_r = worse(cmd.largest, rdb_val_reg, rdb_pos_reg, cur_val_reg, cur_pos_reg);
    assign go_l    = has_r ? (worse_l && !better(cmd.largest, rda_val_reg, rdb_val_reg))
                           : (has_l && worse_l);
    assign go_r    = has_r && !go_l && worse_r;
    assign beaten  = better(cmd.largest, key_reg, rda_val_reg);

    assign rd_pos = rda_pos_reg;

    always_comb
    begin
        ra = '0;
        rb = '0;
        unique case (cmd.op)
            hts_pkg::DP_SIFT_RD:
            begin
                ra = l_sel;
                rb = r_sel;
            end
            hts_pkg::DP_SWAP_RD: rb = addr;
            hts_pkg::DP_RB_RD,
            hts_pkg::DP_EM_RD:   ra = addr;
            default: ;
        endcase
    end

    always_comb
    begin
        we           = 1'b0;
        bp_we        = 1'b0;
        wa           = idx_reg;
        wv           = cur_val_reg;
        wp           = cur_pos_reg;
        cur_val_next = cur_val_reg;
        cur_pos_next = cur_pos_reg;
        idx_next     = idx_reg;
        size_next    = size_reg;
        stat.beaten  = 1'b0;
        stat.stop    = 1'b0;
        unique case (cmd.op)
            hts_pkg::DP_LOAD:
            begin
                cur_val_next = cmd.capture ? key_in : key_reg;
                cur_pos_next = pos_arg;
                idx_next     = addr;
                size_next    = size_arg;
            end
            hts_pkg::DP_REPLACE:
            begin
                stat.beaten = beaten;
                if (beaten)
                begin
                    cur_val_next = key_reg;
                    cur_pos_next = pos_arg;
                    idx_next     = '0;
                    size_next    = size_arg;
                end
            end
            hts_pkg::DP_SIFT_ST:
            begin
                we = 1'b1;
                if (go_l)
                begin
                    wv       = rda_val_reg;
                    wp       = rda_pos_reg;
                    idx_next = l_sel;
                end
                else if (go_r)
                begin
                    wv       = rdb_val_reg;
                    wp       = rdb_pos_reg;
                    idx_next = r_sel;
                end
                else
                    stat.stop = 1'b1;
            end
            hts_pkg::DP_SWAP:
            begin
                // root goes to the tail slot, old tail sifts from the root
                we           = 1'b1;
                wa           = addr;
                wv           = rda_val_reg;
                wp           = rda_pos_reg;
                cur_val_next = rdb_val_reg;
                cur_pos_next = rdb_pos_reg;
                idx_next     = '0;
                size_next    = size_arg;
            end
            hts_pkg::DP_RB_WR: bp_we = 1'b1;
            hts_pkg::DP_BP_LD:
            begin
                cur_val_next = bp_rd_reg;
                cur_pos_next = pos_arg;
                idx_next     = addr;
                size_next    = size_arg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_val_mem[wa] <= wv;
            heap_pos_mem[wa] <= wp;
        end
        if (bp_we)
            bp_mem[KW'(rda_pos_reg)] <= rda_val_reg;
        rda_val_reg <= heap_val_mem[ra];
        rda_pos_reg <= heap_pos_mem[ra];
        rdb_val_reg <= heap_val_mem[rb];
        rdb_pos_reg <= heap_pos_mem[rb];
        bp_rd_reg   <= bp_mem[addr];
        if (cmd.capture)
            key_reg <= key_in;
        cur_val_reg <= cur_val_next;
        cur_pos_reg <= cur_pos_next;
        idx_reg     <= idx_next;
        size_reg    <= size_next;
    end

endmodule

// ----- src/hts_ctrl.sv -----
// ----------------------------------------------------------------------------
// hts_ctrl: sequencer of the heap top-k selector
// Row bookkeeping, configuration registers, insert/sort/emit state machine.
// ----------------------------------------------------------------------------
module hts_ctrl #(
    parameter int MAX_K = 16,
    parameter int MAX_N = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_row_end,
    output logic                                in_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hts_pkg::POSITION_W-1:0]      out_position,
    output logic                                out_final,
    output hts_pkg::hts_cmd_t                   cmd,
    output logic [(MAX_K > 1 ? $clog2(MAX_K) : 1)-1:0] addr,
    output logic [$clog2(MAX_K + 1)-1:0]        size_arg,
    output logic [$clog2(MAX_N)-1:0]            pos_arg,
    input  hts_pkg::hts_stat_t                  stat,
    input  logic [$clog2(MAX_N)-1:0]            rd_pos
);

    localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW = $clog2(MAX_K + 1);
    localparam int PW  = $clog2(MAX_N);
    localparam int CW  = $clog2(MAX_N + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHK     = 4'd1;
    localparam logic [3:0] S_SIFT_RD = 4'd2;
    localparam logic [3:0] S_SIFT_ST = 4'd3;
    localparam logic [3:0] S_END     = 4'd4;
    localparam logic [3:0] S_RB_RD   = 4'd5;
    localparam logic [3:0] S_RB_WR   = 4'd6;
    localparam logic [3:0] S_BP_RD   = 4'd7;
    localparam logic [3:0] S_BP_LD   = 4'd8;
    localparam logic [3:0] S_SW_RD   = 4'd9;
    localparam logic [3:0] S_SW      = 4'd10;
    localparam logic [3:0] S_EM_RD   = 4'd11;
    localparam logic [3:0] S_EM_LD   = 4'd12;
    localparam logic [3:0] S_CNT     = 4'd13;
    localparam logic [3:0] S_WAIT    = 4'd14;

    localparam logic [1:0] PH_INSERT  = 2'd0;
    localparam logic [1:0] PH_REBUILD = 2'd1;
    localparam logic [1:0] PH_SORT    = 2'd2;

    logic [3:0]     state_reg, state_next;
    logic [1:0]     phase_reg, phase_next;
    logic [CW-1:0]  seen_reg, seen_next;
    logic [KCW-1:0] row_k_reg, row_k_next, em_n_reg, em_n_next, lc_reg, lc_next;
    logic           row_sorted_reg, row_sorted_next, row_largest_reg, row_largest_next;
    logic           row_end_reg, row_end_next, cnt_mode_reg, cnt_mode_next;
    logic           out_valid_reg, out_valid_next, out_final_reg, out_final_next;
    logic [hts_pkg::POSITION_W-1:0] out_pos_reg, out_pos_next;
    logic [hts_pkg::CFG_DATA_W-1:0] cfg_keep_reg;
    logic           cfg_sorted_reg, cfg_largest_reg;
    logic [KCW-1:0] k_sat, k_now;
    logic           n_le_k, n_lt_k;

    assign k_sat = (32'(cfg_keep_reg) > 32'(MAX_K)) ? KCW'(MAX_K) : KCW'(cfg_keep_reg);
    assign k_now = (seen_reg == '0) ? k_sat : row_k_reg;
    assign n_le_k = 32'(seen_reg) <= 32'(row_k_reg);
    assign n_lt_k = 32'(seen_reg) <  32'(row_k_reg);

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_position = out_pos_reg;
    assign out_final    = out_final_reg;

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        seen_next        = seen_reg;
        row_k_next       = row_k_reg;
        row_sorted_next  = row_sorted_reg;
        row_largest_next = row_largest_reg;
        row_end_next     = row_end_reg;
        em_n_next        = em_n_reg;
        lc_next          = lc_reg;
        cnt_mode_next    = cnt_mode_reg;
        out_valid_next   = out_valid_reg;
        out_final_next   = out_final_reg;
        out_pos_next     = out_pos_reg;
        cmd.op           = hts_pkg::DP_NOP;
        cmd.capture      = 1'b0;
        cmd.largest      = row_largest_reg;
        addr             = lc_reg[KW-1:0];
        size_arg         = row_k_reg;
        pos_arg          = PW'(seen_reg - CW'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture  = 1'b1;
                    row_end_next = in_row_end;
                    if (seen_reg == '0)
                    begin
                        row_k_next       = k_sat;
                        row_sorted_next  = cfg_sorted_reg;
                        row_largest_next = cfg_largest_reg;
                    end
                    if (32'(seen_reg) < 32'(MAX_N))
                    begin
                        seen_next = seen_reg + CW'(1);
                        if (32'(seen_reg) < 32'(k_now))
                        begin
                            // fill phase: slot k-1-c, sift within k
                            cmd.op     = hts_pkg::DP_LOAD;
                            addr       = KW'(k_now - KCW'(1) - KCW'(seen_reg));
                            size_arg   = k_now;
                            pos_arg    = PW'(seen_reg);
                            phase_next = PH_INSERT;
                            state_next = S_SIFT_RD;
                        end
                        else if (k_now != '0)
                        begin
                            cmd.op     = hts_pkg::DP_RD_ROOT;
                            state_next = S_CHK;
                        end
                        else
                            state_next = S_END;
                    end
                    else
                        state_next = S_END;
                end
            end
            S_CHK:
            begin
                cmd.op = hts_pkg::DP_REPLACE;
                if (stat.beaten)
                begin
                    phase_next = PH_INSERT;
                    state_next = S_SIFT_RD;
                end
                else
                    state_next = S_END;
            end
            S_SIFT_RD:
            begin
                cmd.op     = hts_pkg::DP_SIFT_RD;
                state_next = S_SIFT_ST;
            end
            S_SIFT_ST:
            begin
                cmd.op = hts_pkg::DP_SIFT_ST;
                if (!stat.stop)
                    state_next = S_SIFT_RD;
                else
                begin
                    unique case (phase_reg)
                        PH_REBUILD:
                        begin
                            if (lc_reg + KCW'(1) == em_n_reg)
                            begin
                                if (em_n_reg > KCW'(1))
                                begin
                                    lc_next    = em_n_reg - KCW'(1);
                                    state_next = S_SW_RD;
                                end
                                else
                                begin
                                    lc_next    = '0;
                                    state_next = S_EM_RD;
                                end
                            end
                            else
                            begin
                                lc_next    = lc_reg + KCW'(1);
                                state_next = S_BP_RD;
                            end
                        end
                        PH_SORT:
                        begin
                            if (lc_reg == KCW'(1))
                            begin
                                lc_next    = '0;
                                state_next = S_EM_RD;
                            end
                            else
                            begin
                                lc_next    = lc_reg - KCW'(1);
                                state_next = S_SW_RD;
                            end
                        end
                        default: state_next = S_END;
                    endcase
                end
            end
            S_END:
            begin
                if (!row_end_reg)
                    state_next = S_IDLE;
                else
                begin
                    seen_next = '0;
                    em_n_next = n_le_k ? KCW'(seen_reg) : row_k_reg;
                    if (row_k_reg == '0)
                        state_next = S_IDLE;
                    else if (n_le_k && !row_sorted_reg)
                    begin
                        lc_next    = '0;
                        state_next = S_CNT;
                    end
                    else if (n_lt_k)
                    begin
                        // short sorted row: loaded slots are k-n .. k-1
                        lc_next    = row_k_reg - KCW'(seen_reg);
                        state_next = S_RB_RD;
                    end
                    else if (row_sorted_reg && row_k_reg > KCW'(1))
                    begin
                        lc_next    = row_k_reg - KCW'(1);
                        state_next = S_SW_RD;
                    end
                    else
                    begin
                        lc_next    = '0;
                        state_next = S_EM_RD;
                    end
                end
            end
            S_RB_RD:
            begin
                cmd.op     = hts_pkg::DP_RB_RD;
                state_next = S_RB_WR;
            end
            S_RB_WR:
            begin
                cmd.op = hts_pkg::DP_RB_WR;
                if (lc_reg == row_k_reg - KCW'(1))
                begin
                    lc_next    = '0;
                    state_next = S_BP_RD;
                end
                else
                begin
                    lc_next    = lc_reg + KCW'(1);
                    state_next = S_RB_RD;
                end
            end
            S_BP_RD:
            begin
                cmd.op     = hts_pkg::DP_BP_RD;
                state_next = S_BP_LD;
            end
            S_BP_LD:
            begin
                cmd.op     = hts_pkg::DP_BP_LD;
                addr       = KW'(em_n_reg - KCW'(1) - lc_reg);
                size_arg   = em_n_reg;
                pos_arg    = PW'(lc_reg);
                phase_next = PH_REBUILD;
                state_next = S_SIFT_RD;
            end
            S_SW_RD:
            begin
                cmd.op     = hts_pkg::DP_SWAP_RD;
                state_next = S_SW;
            end
            S_SW:
            begin
                cmd.op     = hts_pkg::DP_SWAP;
                size_arg   = lc_reg;
                phase_next = PH_SORT;
                state_next = S_SIFT_RD;
            end
            S_EM_RD:
            begin
                cmd.op     = hts_pkg::DP_EM_RD;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                out_pos_next   = hts_pkg::POSITION_W'(rd_pos);
                out_valid_next = 1'b1;
                out_final_next = (lc_reg == em_n_reg - KCW'(1));
                cnt_mode_next  = 1'b0;
                state_next     = S_WAIT;
            end
            S_CNT:
            begin
                out_pos_next   = hts_pkg::POSITION_W'(lc_reg);
                out_valid_next = 1'b1;
                out_final_next = (lc_reg == em_n_reg - KCW'(1));
                cnt_mode_next  = 1'b1;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_final_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        lc_next    = lc_reg + KCW'(1);
                        state_next = cnt_mode_reg ? S_CNT : S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_INSERT;
            seen_reg        <= '0;
            row_k_reg       <= KCW'(1);
            row_sorted_reg  <= 1'b1;
            row_largest_reg <= 1'b1;
            row_end_reg     <= 1'b0;
            em_n_reg        <= '0;
            lc_reg          <= '0;
            cnt_mode_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_final_reg   <= 1'b0;
            cfg_keep_reg    <= hts_pkg::CFG_DATA_W'(1);
            cfg_sorted_reg  <= 1'b1;
            cfg_largest_reg <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            seen_reg        <= seen_next;
            row_k_reg       <= row_k_next;
            row_sorted_reg  <= row_sorted_next;
            row_largest_reg <= row_largest_next;
            row_end_reg     <= row_end_next;
            em_n_reg        <= em_n_next;
            lc_reg          <= lc_next;
            cnt_mode_reg    <= cnt_mode_next;
            out_valid_reg   <= out_valid_next;
            out_final_reg   <= out_final_next;
            if (cfg_we)
            begin
                priority case (cfg_index)
                    hts_pkg::CFG_KEEP_COUNT:    cfg_keep_reg    <= cfg_wdata;
                    hts_pkg::CFG_SORTED_OUTPUT: cfg_sorted_reg  <= cfg_wdata[0];
                    hts_pkg::CFG_LARGEST_MODE:  cfg_largest_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_pos_reg <= out_pos_next;
    end

endmodule

// ----- src/heap_topk_index_select.sv -----
// ----------------------------------------------------------------------------
// heap_topk_index_select: streaming top-k position selector
// Per item: an accept state, a root compare (replacement only), a memory
//   read and a compare/write state per visited sift level, and an end state.
// Row end: sorted mode runs k-1 swap+sift passes (n-1 for a rebuilt short row),
//   then each emitted position passes a read, a load and a wait state, held
//   until the sink is ready (count and wait for a row of at most k in heap order).
// Reset initialises control and configuration; heap memories are not cleared.
// ----------------------------------------------------------------------------
module heap_topk_index_select #(
    parameter int MAX_K      = 16,
    parameter int MAX_N      = 65536,
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    hts_in_if.sink                         in_ch,
    hts_out_if.source                      out_ch
);

    // One item is worked on at a time. The heap lives in a two-read,
    // one-write memory; a sift-down keeps the moving entry in a register
    // and walks it down one level per read and compare/write, which sets the rate.
    // Short sorted rows go through a by-position buffer before rebuilding.

    localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW = $clog2(MAX_K + 1);
    localparam int PW  = $clog2(MAX_N);

    hts_pkg::hts_cmd_t  cmd;
    hts_pkg::hts_stat_t stat;
    logic [KW-1:0]      addr;
    logic [KCW-1:0]     size_arg;
    logic [PW-1:0]      pos_arg, rd_pos;

    hts_ctrl #(
        .MAX_K (MAX_K),
        .MAX_N (MAX_N)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_ch.valid),
        .in_row_end   (in_ch.row_end),
        .in_ready     (in_ch.ready),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_position (out_ch.position),
        .out_final    (out_ch.final_result),
        .cmd          (cmd),
        .addr         (addr),
        .size_arg     (size_arg),
        .pos_arg      (pos_arg),
        .stat         (stat),
        .rd_pos       (rd_pos)
    );

    hts_datapath #(
        .MAX_K      (MAX_K),
        .MAX_N      (MAX_N),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .addr         (addr),
        .size_arg     (size_arg),
        .pos_arg      (pos_arg),
        .sample_value (in_ch.sample_value),
        .stat         (stat),
        .rd_pos       (rd_pos)
    );

endmodule
